// File: hw/rtl/msop_pkg.sv
// Shared constants, codes and types of the matrix scan order placer.
`default_nettype none

package msop_pkg;

  // Largest matrix side; the scan generator clamps the side to it
  localparam int MAX_SIDE   = 64;

  // Field widths
  localparam int COORD_W    = 6;
  localparam int SIDE_W     = 7;
  localparam int MODE_W     = 2;
  localparam int ELEM_W     = 64;
  localparam int COUNT_W    = $clog2(MAX_SIDE * MAX_SIDE);
  localparam int TOTAL_W    = COUNT_W + 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = SIDE_W;
  localparam int IN_TDATA_W  = 2 * ELEM_W;
  localparam int OUT_FIELD_W = 2 * COORD_W + 2 * ELEM_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SCAN_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIDE_LENGTH = 2'd1;

  // Scan orders
  localparam logic [MODE_W-1:0] MODE_ROW_MAJOR = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SNAKE     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ZIGZAG    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SPIRAL    = 2'd3;

  // Spiral legs
  localparam logic [1:0] DIR_RIGHT = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_UP    = 2'd3;

  // Commands from the top level to the address generator
  typedef struct packed {
    logic restart;   // settings changed: re-walk to the current element
    logic step;      // a word was accepted: advance to the next element
  } scan_ctrl_t;

  // Placement of the element that the next accepted word takes
  typedef struct packed {
    logic               busy;
    logic               last;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
  } scan_pos_t;

  // One result word
  typedef struct packed {
    logic              last;
    logic [ELEM_W-1:0] imag;
    logic [ELEM_W-1:0] real_bits;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
  } out_word_t;

endpackage

`default_nettype wire

// File: hw/rtl/msop_scan_gen.sv
// Scan address generator: element count and stepped matrix position per scan order.
`default_nettype none

module msop_scan_gen (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire [msop_pkg::MODE_W-1:0]  scan_mode,
  input  wire [msop_pkg::SIDE_W-1:0]  side_length,
  input  msop_pkg::scan_ctrl_t        ctrl,
  output msop_pkg::scan_pos_t         pos
);

  import msop_pkg::*;

  logic [COUNT_W-1:0]  count_r, count_nxt;
  logic [COUNT_W-1:0]  target_r, target_nxt;
  logic                resync_r, resync_nxt;
  logic [COORD_W-1:0]  row_r, row_nxt, col_r, col_nxt, ring_r, ring_nxt;
  logic [1:0]          dir_r, dir_nxt;

  logic [SIDE_W-1:0]   side_n;
  logic [TOTAL_W-1:0]  total;
  logic [COORD_W-1:0]  n_m1, hi_sp, ring_p1;
  logic [COUNT_W-1:0]  eff_target;
  logic                last, at_target, advance, diag_odd;
  logic [COORD_W-1:0]  row_step, col_step, ring_step;
  logic [1:0]          dir_step;

  // Clamp the side into 1..MAX_SIDE
  always_comb begin
    if (side_length == '0) begin
      side_n = SIDE_W'(1);
    end else if (side_length > SIDE_W'(MAX_SIDE)) begin
      side_n = SIDE_W'(MAX_SIDE);
    end else begin
      side_n = side_length;
    end
  end

  assign total      = TOTAL_W'(side_n) * TOTAL_W'(side_n);
  assign n_m1       = COORD_W'(side_n - SIDE_W'(1));
  assign hi_sp      = n_m1 - ring_r;
  assign ring_p1    = ring_r + COORD_W'(1);
  assign diag_odd   = row_r[0] ^ col_r[0];
  assign last       = ({1'b0, count_r} == (total - TOTAL_W'(1)));
  assign eff_target = ({1'b0, target_r} >= total) ? '0 : target_r;
  assign at_target  = (count_r == eff_target);
  assign advance    = ctrl.step | (resync_r & ~at_target);

  // One step along the selected order
  always_comb begin
    row_step  = row_r;
    col_step  = col_r;
    dir_step  = dir_r;
    ring_step = ring_r;
    unique case (scan_mode)
      MODE_ROW_MAJOR: begin
        if (col_r == n_m1) begin
          row_step = row_r + COORD_W'(1);
          col_step = '0;
        end else begin
          col_step = col_r + COORD_W'(1);
        end
      end
      MODE_SNAKE: begin
        if (!row_r[0]) begin
          if (col_r == n_m1) row_step = row_r + COORD_W'(1);
          else               col_step = col_r + COORD_W'(1);
        end else begin
          if (col_r == '0) row_step = row_r + COORD_W'(1);
          else             col_step = col_r - COORD_W'(1);
        end
      end
      MODE_ZIGZAG: begin
        if (!diag_odd) begin
          // up and to the right
          if (col_r == n_m1) begin
            row_step = row_r + COORD_W'(1);
          end else if (row_r == '0) begin
            col_step = col_r + COORD_W'(1);
          end else begin
            row_step = row_r - COORD_W'(1);
            col_step = col_r + COORD_W'(1);
          end
        end else begin
          // down and to the left
          if (row_r == n_m1) begin
            col_step = col_r + COORD_W'(1);
          end else if (col_r == '0) begin
            row_step = row_r + COORD_W'(1);
          end else begin
            row_step = row_r + COORD_W'(1);
            col_step = col_r - COORD_W'(1);
          end
        end
      end
      MODE_SPIRAL: begin
        unique case (dir_r)
          DIR_RIGHT: begin
            if (col_r == hi_sp) begin
              dir_step = DIR_DOWN;
              row_step = row_r + COORD_W'(1);
            end else begin
              col_step = col_r + COORD_W'(1);
            end
          end
          DIR_DOWN: begin
            if (row_r == hi_sp) begin
              dir_step = DIR_LEFT;
              col_step = col_r - COORD_W'(1);
            end else begin
              row_step = row_r + COORD_W'(1);
            end
          end
          DIR_LEFT: begin
            if (col_r == ring_r) begin
              if (row_r == ring_p1) begin
                ring_step = ring_p1;
                row_step  = ring_p1;
                col_step  = ring_p1;
                dir_step  = DIR_RIGHT;
              end else begin
                dir_step = DIR_UP;
                row_step = row_r - COORD_W'(1);
              end
            end else begin
              col_step = col_r - COORD_W'(1);
            end
          end
          DIR_UP: begin
            if (row_r == ring_p1) begin
              ring_step = ring_p1;
              row_step  = ring_p1;
              col_step  = ring_p1;
              dir_step  = DIR_RIGHT;
            end else begin
              row_step = row_r - COORD_W'(1);
            end
          end
        endcase
      end
    endcase
  end

  always_comb begin
    count_nxt  = count_r;
    target_nxt = target_r;
    resync_nxt = resync_r;
    row_nxt    = row_r;
    col_nxt    = col_r;
    dir_nxt    = dir_r;
    ring_nxt   = ring_r;
    if (ctrl.restart) begin
      // restart from the origin and walk back up to the element count
      target_nxt = resync_r ? target_r : count_r;
      resync_nxt = 1'b1;
      count_nxt  = '0;
      row_nxt    = '0;
      col_nxt    = '0;
      dir_nxt    = DIR_RIGHT;
      ring_nxt   = '0;
    end else begin
      if (resync_r && at_target) resync_nxt = 1'b0;
      if (advance) begin
        if (last) begin
          count_nxt = '0;
          row_nxt   = '0;
          col_nxt   = '0;
          dir_nxt   = DIR_RIGHT;
          ring_nxt  = '0;
        end else begin
          count_nxt = count_r + COUNT_W'(1);
          row_nxt   = row_step;
          col_nxt   = col_step;
          dir_nxt   = dir_step;
          ring_nxt  = ring_step;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      target_r <= '0;
      resync_r <= 1'b0;
      row_r    <= '0;
      col_r    <= '0;
      dir_r    <= DIR_RIGHT;
      ring_r   <= '0;
    end else begin
      count_r  <= count_nxt;
      target_r <= target_nxt;
      resync_r <= resync_nxt;
      row_r    <= row_nxt;
      col_r    <= col_nxt;
      dir_r    <= dir_nxt;
      ring_r   <= ring_nxt;
    end
  end

  assign pos.busy = resync_r;
  assign pos.last = last;
  assign pos.row  = row_r;
  assign pos.col  = col_r;

endmodule

`default_nettype wire

// File: hw/rtl/msop_skid.sv
// Two-word output buffer: result register plus skid register.
`default_nettype none

module msop_skid (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  push,
  input  msop_pkg::out_word_t  push_word,
  output logic                 full,
  output logic                 out_valid,
  input  wire                  out_ready,
  output msop_pkg::out_word_t  out_word
);

  import msop_pkg::*;

  logic      main_vld_r, main_vld_nxt, skid_vld_r, skid_vld_nxt;
  out_word_t main_r, main_nxt, skid_r, skid_nxt;
  logic      pop;

  assign pop = main_vld_r & out_ready;

  always_comb begin
    main_vld_nxt = main_vld_r;
    skid_vld_nxt = skid_vld_r;
    main_nxt     = main_r;
    skid_nxt     = skid_r;
    if (skid_vld_r) begin
      // drain the skid word once the head is taken
      if (pop) begin
        main_nxt     = skid_r;
        skid_vld_nxt = 1'b0;
      end
    end else if (!main_vld_r || pop) begin
      main_vld_nxt = push;
      if (push) main_nxt = push_word;
    end else if (push) begin
      skid_nxt     = push_word;
      skid_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      main_vld_r <= main_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign full      = skid_vld_r;
  assign out_valid = main_vld_r;
  assign out_word  = main_r;

endmodule

`default_nettype wire

// File: hw/rtl/matrix_scan_order_placer.sv
// Top level of the matrix scan order placer: settings, scan generator and output buffer.
//
// Each word on the in_ channel is one vector element; the word on the out_
// channel gives the matrix row and column where it goes, the element bits
// unchanged, and out_tlast on the element that fills the final position,
// after which the count starts again from the first position.
// Settings are written through cfg_: index 0 the scan order (row-major,
// snake, zigzag, clockwise spiral), index 1 the side (0 reads as 1, values
// above 64 as 64). Other indexes are ignored.
// A taken word is registered into the result register, or into the skid register while the head waits.
// Throughput: one word per cycle while in_tready stays high, set by the single-step position update.
// When the receiver stalls, the result register and a skid register hold
// up to two words; in_tready falls only once both are occupied.
// After every settings write to index 0 or 1 the generator steps from the origin up
// to the current element count (or stays at the origin if that count lies past the
// new matrix) under the new settings, one element a cycle, with in_tready low.
// Reset: order row-major, side 8, count zero, output buffer empty.
`default_nettype none

module matrix_scan_order_placer (
  input  wire                                 clk,
  input  wire                                 rst_n,
  // input words
  input  wire                                 in_tvalid,
  output logic                                in_tready,
  input  wire [msop_pkg::IN_TDATA_W-1:0]      in_tdata,   // element_real_bits, element_imag_bits
  // result words
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  output logic [msop_pkg::OUT_TDATA_W-1:0]    out_tdata,  // dest_row, dest_col, out_real_bits,
                                                          // out_imag_bits, zero fill
  output logic                                out_tlast,  // last_of_matrix
  // settings
  input  wire                                 cfg_wr_en,
  input  wire [msop_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire [msop_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  import msop_pkg::*;

  logic [MODE_W-1:0] scan_mode_r, scan_mode_nxt;
  logic [SIDE_W-1:0] side_length_r, side_length_nxt;
  logic              cfg_hit;
  logic              in_acc;
  logic              skid_full;
  scan_ctrl_t        scan_ctrl;
  scan_pos_t         scan_pos;
  out_word_t         push_word, head_word;

  // Settings registers; a write to a known index also restarts the walk
  always_comb begin
    scan_mode_nxt   = scan_mode_r;
    side_length_nxt = side_length_r;
    cfg_hit         = 1'b0;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_SCAN_MODE: begin
          scan_mode_nxt = cfg_wdata[MODE_W-1:0];
          cfg_hit       = 1'b1;
        end
        REG_SIDE_LENGTH: begin
          side_length_nxt = cfg_wdata[SIDE_W-1:0];
          cfg_hit         = 1'b1;
        end
        default: begin
          cfg_hit = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_mode_r   <= MODE_ROW_MAJOR;
      side_length_r <= SIDE_W'(8);
    end else begin
      scan_mode_r   <= scan_mode_nxt;
      side_length_r <= side_length_nxt;
    end
  end

  // Hold off input while the generator re-walks, during a write, or with the buffer full
  assign in_tready = ~skid_full & ~scan_pos.busy & ~cfg_wr_en;
  assign in_acc    = in_tvalid & in_tready;

  assign scan_ctrl.restart = cfg_hit;
  assign scan_ctrl.step    = in_acc;

  msop_scan_gen u_scan_gen (
    .clk         (clk),
    .rst_n       (rst_n),
    .scan_mode   (scan_mode_r),
    .side_length (side_length_r),
    .ctrl        (scan_ctrl),
    .pos         (scan_pos)
  );

  // Pair the element with the position the generator holds for it
  assign push_word.row       = scan_pos.row;
  assign push_word.col       = scan_pos.col;
  assign push_word.real_bits = in_tdata[ELEM_W-1:0];
  assign push_word.imag      = in_tdata[2*ELEM_W-1:ELEM_W];
  assign push_word.last      = scan_pos.last;

  msop_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_acc),
    .push_word (push_word),
    .full      (skid_full),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_word  (head_word)
  );

  assign out_tdata = {(OUT_TDATA_W - OUT_FIELD_W)'(0), head_word.imag, head_word.real_bits,
                      head_word.col, head_word.row};
  assign out_tlast = head_word.last;

`ifndef SYNTHESIS
  // No word may enter while the generator is re-walking
  a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    scan_pos.busy |-> !in_tready)
    else $error("input taken during position re-walk");

  // A settings write to a known index always starts a re-walk
  a_restart_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_hit |=> scan_pos.busy)
    else $error("settings write did not start a re-walk");

  // After the final element the next one goes to the origin
  a_wrap_to_origin: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && scan_pos.last) |=> (scan_pos.row == '0 && scan_pos.col == '0))
    else $error("position did not wrap after the final element");

  // A word in the skid register implies a word at the head
  a_skid_behind_head: assert property (@(posedge clk) disable iff (!rst_n)
    skid_full |-> out_tvalid)
    else $error("skid word held with empty head");
`endif

endmodule

`default_nettype wire

// File: test/matrix_scan_order_placer_tb.sv
// Testbench of the matrix scan order placer: directed table, random phases, own placement model.
`timescale 1ns / 1ps

module matrix_scan_order_placer_tb;
  import msop_pkg::*;

  // Indexes that address no register; writes to them must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_B = 2'd3;

  localparam int RANDOM_WORDS = 1000;
  localparam int IDLE_PCT     = 19;
  localparam int LIMIT_CYCLES = 3_000_000;
  localparam int N_DIRECTED   = 35;

  localparam logic [ELEM_W-1:0] ALT_A = 64'hAAAA_AAAA_AAAA_AAAA;
  localparam logic [ELEM_W-1:0] ALT_5 = 64'h5555_5555_5555_5555;

  typedef enum logic {ST_WORD, ST_WRITE} step_kind_t;

  // One row of the directed table: either a settings write or a word, the latter
  // optionally carrying a placement typed in by hand
  typedef struct packed {
    step_kind_t             kind;
    logic [CFG_IDX_W-1:0]   reg_idx;
    logic [CFG_DATA_W-1:0]  reg_val;
    logic [ELEM_W-1:0]      re;
    logic [ELEM_W-1:0]      im;
    logic                   fixed;
    logic [COORD_W-1:0]     row;
    logic [COORD_W-1:0]     col;
    logic                   last;
  } step_t;

  // Where one element lands, plus the bits that travel with it
  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [ELEM_W-1:0]  re;
    logic [ELEM_W-1:0]  im;
    logic               last;
  } placement_t;

  logic                    clk;
  logic                    rst_n;
  logic                    in_tvalid;
  logic                    in_tready;
  logic [IN_TDATA_W-1:0]   in_tdata;
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]  out_tdata;
  logic                    out_tlast;
  logic                    cfg_wr_en;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_wdata;

  // Shadow settings and element count of the placement model
  logic [MODE_W-1:0]  scan_order;
  logic [SIDE_W-1:0]  side_reg;
  int                 elem_index;

  placement_t placements_due[$];
  step_t      directed_steps [0:N_DIRECTED-1];

  bit  no_idle = 1'b0;
  int  mismatches = 0;
  int  results_seen = 0;
  int  words_sent = 0;
  int  phases_run = 0;
  int  cycles = 0;

  matrix_scan_order_placer i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),     // element_real_bits, element_imag_bits
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),    // dest_row, dest_col, out_real_bits, out_imag_bits, zero fill
    .out_tlast  (out_tlast),    // last_of_matrix
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Work out where the next element goes under the shadow settings, and
  // advance the element count exactly as the block does
  function automatic placement_t place_word(logic [ELEM_W-1:0] re, logic [ELEM_W-1:0] im);
    placement_t p;
    int n, total, k, r, c, kk, d, lo, hi, len, ring, m, cells;
    bit found;
    // a side of zero reads as one, anything past the maximum as the maximum
    n = (side_reg == 0) ? 1 : ((side_reg > MAX_SIDE) ? MAX_SIDE : int'(side_reg));
    total = n * n;
    // a count left beyond a shrunken matrix starts over at the first element
    k = (elem_index >= total) ? 0 : elem_index;
    r = 0;
    c = 0;
    kk = k;
    found = 1'b0;
    case (scan_order)
      MODE_ROW_MAJOR: begin
        r = k / n;
        c = k % n;
      end
      MODE_SNAKE: begin
        r = k / n;
        c = k % n;
        if (r % 2 == 1) c = n - 1 - c;
      end
      MODE_ZIGZAG: begin
        // walk the anti-diagonals; even ones run upwards, odd ones downwards
        for (d = 0; d < 2 * n - 1 && !found; d++) begin
          lo = (d >= n) ? d - n + 1 : 0;
          hi = (d < n) ? d : n - 1;
          len = hi - lo + 1;
          if (kk < len) begin
            r = (d % 2 == 0) ? hi - kk : lo + kk;
            c = d - r;
            found = 1'b1;
          end else begin
            kk -= len;
          end
        end
      end
      default: begin
        // peel rings from the outside; an odd side leaves the centre on its own
        ring = 0;
        while (!found && n >= 2 * ring + 2) begin
          m = n - 2 * ring;
          cells = 4 * m - 4;
          if (kk < cells) begin
            found = 1'b1;
            if (kk < m) begin
              r = ring;
              c = ring + kk;
            end else if (kk < 2 * m - 1) begin
              r = ring + 1 + (kk - m);
              c = ring + m - 1;
            end else if (kk < 3 * m - 2) begin
              r = ring + m - 1;
              c = ring + m - 2 - (kk - (2 * m - 1));
            end else begin
              r = ring + m - 2 - (kk - (3 * m - 2));
              c = ring;
            end
          end else begin
            kk -= cells;
            ring++;
          end
        end
        if (!found) begin
          r = ring;
          c = ring;
        end
      end
    endcase
    p.row  = r[COORD_W-1:0];
    p.col  = c[COORD_W-1:0];
    p.re   = re;
    p.im   = im;
    p.last = (k == total - 1);
    elem_index = p.last ? 0 : k + 1;
    return p;
  endfunction

  // Offer one word, hold it until taken, then queue its placement; a fixed
  // placement from the table replaces the model's but the count still advances
  task automatic send_word(input logic [ELEM_W-1:0] re, input logic [ELEM_W-1:0] im,
                           input logic fixed, input placement_t typed);
    placement_t p;
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {im, re};
    do @(posedge clk); while (in_tready !== 1'b1);
    p = place_word(re, im);
    if (fixed) begin
      p.row  = typed.row;
      p.col  = typed.col;
      p.last = typed.last;
    end
    placements_due.push_back(p);
    words_sent++;
  endtask

  // Drop valid and wait until every placement owed has come back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (placements_due.size() != 0) @(posedge clk);
  endtask

  // One settings write, after which write enable drops before the task returns, so writes never abut
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_SCAN_MODE:   scan_order = val[MODE_W-1:0];
      REG_SIDE_LENGTH: side_reg = val;
      default: ;
    endcase
  endtask

  task automatic report_field(input string name, input logic [ELEM_W-1:0] want,
                              input logic [ELEM_W-1:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  // Result side: take a word whenever valid meets ready, compare it with the
  // oldest placement owed, and pick ready for the next edge
  always @(posedge clk) begin : result_check
    placement_t want;
    if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready) begin
      results_seen++;
      if (placements_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result word, expected none, actual tdata %h", $time,
                 out_tdata);
      end else begin
        want = placements_due.pop_front();
        report_field("dest_row", ELEM_W'(want.row), ELEM_W'(out_tdata[COORD_W-1:0]));
        report_field("dest_col", ELEM_W'(want.col),
                     ELEM_W'(out_tdata[2*COORD_W-1:COORD_W]));
        report_field("out_real_bits", want.re, out_tdata[2*COORD_W+ELEM_W-1:2*COORD_W]);
        report_field("out_imag_bits", want.im,
                     out_tdata[2*COORD_W+2*ELEM_W-1:2*COORD_W+ELEM_W]);
        report_field("last_of_matrix", ELEM_W'(want.last), ELEM_W'(out_tlast));
      end
    end
    out_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Watchdog: give up on a hung handshake
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d placements still owed", cycles,
               placements_due.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    placement_t         typed;
    logic [SIDE_W-1:0]  side_val;
    int                 pick;
    int                 words;
    int                 random_words;

    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_wr_en <= 1'b0;
    cfg_index <= REG_SCAN_MODE;
    cfg_wdata <= '0;
    rst_n     <= 1'b0;
    scan_order = MODE_ROW_MAJOR;
    side_reg   = 7'd8;
    elem_index = 0;

    // Directed part. Typed placements: first words after reset (row-major,
    // side 8), a count stranded beyond a shrunken matrix, a side of zero,
    // writes to unused indexes, an oversized side, and the spiral centre.
    directed_steps = '{
      '{ST_WORD,  REG_SCAN_MODE,   7'd0,  '0,    '0,    1'b1, 6'd0, 6'd0, 1'b0},
      '{ST_WORD,  REG_SCAN_MODE,   7'd0,  '1,    '1,    1'b1, 6'd0, 6'd1, 1'b0},
      '{ST_WRITE, REG_SIDE_LENGTH, 7'd1,  '0,    '0,    1'b0, 6'd0, 6'd0, 1'b0},
      '{ST_WORD,  REG_SCAN_MODE,   7'd0,  ALT_A, ALT_5, 1'b1, 6'd0, 6'd0, 1'b1},
      '{ST_WRITE, REG_SIDE_LENGTH, 7'd0,  '0,    '0,    1'b0, 6'd0, 6'd0, 1'b0},
      '{ST_WORD,  REG_SCAN_MODE,   7'd0,  ALT_5, ALT_A, 1'b1, 6'd0, 6'd0, 1'b1},
      '{ST_WRITE, REG_UNUSED_A,    '1,    '0,    '0,    1'b0, 6'd0, 6'd0, 1'b0},
      '{ST_WRITE, REG_UNUSED_B,    '1,    '0,    '0,    1'b0, 6'd0, 6'd0, 1'b0},
      '{ST_WORD,  REG_SCAN_MODE,   7'd0,  '1,    '0,    1'b1, 6'd0, 6'd0, 1'b1},
      '{ST_WRITE, REG_SIDE_LENGTH, '1,    '0,    '0,    1'b0, 6'd0, 6'd0, 1'b0},
      '{ST_WRITE, REG_SCAN_MODE,   {5'h1F, MODE_SPIRAL}, '0, '0, 1'b0, 6'd0, 6'd0, 1'b0},
      '{ST_WORD,  REG_SCAN_MODE,   7'd0,  '0,    '1,    1'b1, 6'd0, 6'd0, 1'b0},
      '{ST_WORD,  REG_SCAN_MODE,   7'd0,  ALT_A, ALT_A, 1'b1, 6'd0, 6'd1, 1'b0},
      // shrink to 3 mid-matrix: the spiral carries on from the third element
      '{ST_WRITE, REG_SIDE_LENGTH, 7'd3,  '0,    '0,    1'b0, 6'd0, 6'd0, 1'b0},
      '{ST_WORD,  REG_SCAN_MODE,   7'd0,  ALT_5, ALT_5, 1'b1, 6'd0, 6'd2, 1'b0},
      '{ST_WORD,  REG_SCAN_MODE,   7'd0,  64'd3, 64'd30, 1'b0, 6'd0, 6'd0, 1'b0},
      '{ST_WORD,  REG_SCAN_MODE,   7'd0,  64'd4, 64'd40, 1'b0, 6'd0, 6'd0, 1'b0},
      '{ST_WORD,  REG_SCAN_MODE,   7'd0,  64'd5, 64'd50, 1'b0, 6'd0, 6'd0, 1'b0},
      '{ST_WORD,  REG_SCAN_MODE,   7'd0,  64'd6, 64'd60, 1'b0, 6'd0, 6'd0, 1'b0},
      '{ST_WORD,  REG_SCAN_MODE,   7'd0,  64'd7, 64'd70, 1'b0, 6'd0, 6'd0, 1'b0},
      '{ST_WORD,  REG_SCAN_MODE,   7'd0,  64'd8, 64'd80, 1'b1, 6'd1, 6'd1, 1'b1},
      '{ST_WRITE, REG_SCAN_MODE,   {5'h01, MODE_ZIGZAG}, '0, '0, 1'b0, 6'd0, 6'd0, 1'b0},
      '{ST_WRITE, REG_SIDE_LENGTH, 7'd4,  '0,    '0,    1'b0, 6'd0, 6'd0, 1'b0},
      '{ST_WORD,  REG_SCAN_MODE,   7'd0,  64'd10, ALT_A, 1'b0, 6'd0, 6'd0, 1'b0},
      '{ST_WORD,  REG_SCAN_MODE,   7'd0,  64'd11, ALT_5, 1'b0, 6'd0, 6'd0, 1'b0},
      '{ST_WORD,  REG_SCAN_MODE,   7'd0,  64'd12, ALT_A, 1'b0, 6'd0, 6'd0, 1'b0},
      '{ST_WORD,  REG_SCAN_MODE,   7'd0,  64'd13, ALT_5, 1'b0, 6'd0, 6'd0, 1'b0},
      '{ST_WORD,  REG_SCAN_MODE,   7'd0,  64'd14, ALT_A, 1'b0, 6'd0, 6'd0, 1'b0},
      '{ST_WORD,  REG_SCAN_MODE,   7'd0,  64'd15, ALT_5, 1'b0, 6'd0, 6'd0, 1'b0},
      // snake on side 2; the count of six lies past the matrix, so start over
      '{ST_WRITE, REG_SCAN_MODE,   {5'h00, MODE_SNAKE}, '0, '0, 1'b0, 6'd0, 6'd0, 1'b0},
      '{ST_WRITE, REG_SIDE_LENGTH, 7'd2,  '0,    '0,    1'b0, 6'd0, 6'd0, 1'b0},
      '{ST_WORD,  REG_SCAN_MODE,   7'd0,  ALT_A, 64'd1, 1'b0, 6'd0, 6'd0, 1'b0},
      '{ST_WORD,  REG_SCAN_MODE,   7'd0,  ALT_5, 64'd2, 1'b0, 6'd0, 6'd0, 1'b0},
      '{ST_WORD,  REG_SCAN_MODE,   7'd0,  ALT_A, 64'd3, 1'b0, 6'd0, 6'd0, 1'b0},
      '{ST_WORD,  REG_SCAN_MODE,   7'd0,  ALT_5, 64'd4, 1'b0, 6'd0, 6'd0, 1'b0}
    };

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the table; settings change only once all owed words are back
    foreach (directed_steps[i]) begin
      if (directed_steps[i].kind == ST_WRITE) begin
        drain_results();
        write_reg(directed_steps[i].reg_idx, directed_steps[i].reg_val);
      end else begin
        typed.row  = directed_steps[i].row;
        typed.col  = directed_steps[i].col;
        typed.last = directed_steps[i].last;
        typed.re   = directed_steps[i].re;
        typed.im   = directed_steps[i].im;
        send_word(directed_steps[i].re, directed_steps[i].im, directed_steps[i].fixed, typed);
      end
    end

    // Random phases: fresh settings, then a burst of words. The first phase
    // sweeps the outer spiral ring of the largest matrix so that every bit of
    // row and column toggles; a few early phases run with no idling at all.
    typed = '0;
    random_words = 0;
    while (random_words < RANDOM_WORDS) begin
      drain_results();
      no_idle <= (phases_run >= 2 && phases_run <= 6);
      if (phases_run == 0) begin
        write_reg(REG_SCAN_MODE, {5'($urandom_range(0, 31)), MODE_SPIRAL});
        write_reg(REG_SIDE_LENGTH, 7'(MAX_SIDE));
        words = 260;
      end else begin
        // mode only, both, or side only; a register left alone keeps its value
        pick = $urandom_range(0, 9);
        if (pick < 7) write_reg(REG_SCAN_MODE, 7'($urandom_range(0, 127)));
        if (pick > 2) begin
          pick = $urandom_range(0, 99);
          if (pick < 70)      side_val = 7'($urandom_range(1, 8));
          else if (pick < 85) side_val = 7'($urandom_range(9, 16));
          else if (pick < 93) side_val = 7'($urandom_range(17, MAX_SIDE));
          else if (pick < 96) side_val = '0;
          else                side_val = 7'($urandom_range(MAX_SIDE + 1, 127));
          write_reg(REG_SIDE_LENGTH, side_val);
        end
        if ($urandom_range(0, 7) == 0)
          write_reg($urandom_range(0, 1) ? REG_UNUSED_A : REG_UNUSED_B,
                    7'($urandom_range(0, 127)));
        words = $urandom_range(1, 48);
      end
      repeat (words) begin
        send_word({$urandom, $urandom}, {$urandom, $urandom}, 1'b0, typed);
        random_words++;
      end
      phases_run++;
    end

    // Let the last words come back, then allow for the output buffer depth
    drain_results();
    no_idle <= 1'b0;
    repeat (4) @(posedge clk);

    $display("Sent %0d words (%0d random) over %0d random settings phases", words_sent,
             random_words, phases_run);
    $display("Checked %0d placements across all four scan orders in %0d cycles",
             results_seen, cycles);
    if (mismatches == 0 && placements_due.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
